// ===== rtl/gwe_pkg.sv =====
// ---------------------------------------------------------------------------
// gwe_pkg
// Shared types and constants for the graph walk engine.
// ---------------------------------------------------------------------------
package gwe_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = STORE_AW + 1;
    localparam int NCOUNT_W    = 7;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_ROW,
        S_SCAN,
        S_DROP_RD,
        S_DROP_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic take;
        logic latch_row;
        logic scan;
        logic drop_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic head_visited;
        logic drop_en;
    } t_dp_stat;

endpackage

// ===== rtl/gwe_ctrl.sv =====
// ---------------------------------------------------------------------------
// gwe_ctrl
// Sequencer for request handling: take, row fetch, scan and head cleanup.
// ---------------------------------------------------------------------------
module gwe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_req_type,
    input  gwe_pkg::t_dp_stat i_stat,
    output gwe_pkg::t_dp_cmd  o_cmd,
    output logic             busy,
    output logic             o_valid
);

    gwe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gwe_pkg::S_IDLE: begin
                if (start) begin
                    if (i_req_type == gwe_pkg::REQ_STEP && !i_stat.count_zero)
                        n_state = gwe_pkg::S_TAKE;
                    else
                        n_state = gwe_pkg::S_DONE;
                end
            end
            gwe_pkg::S_TAKE:    n_state = gwe_pkg::S_ROW;
            gwe_pkg::S_ROW:     n_state = gwe_pkg::S_SCAN;
            gwe_pkg::S_SCAN: begin
                if (i_stat.scan_last) n_state = gwe_pkg::S_DROP_RD;
            end
            gwe_pkg::S_DROP_RD: begin
                if (i_stat.drop_en && !i_stat.count_zero)
                    n_state = gwe_pkg::S_DROP_CHK;
                else
                    n_state = gwe_pkg::S_DONE;
            end
            gwe_pkg::S_DROP_CHK: begin
                if (i_stat.head_visited) n_state = gwe_pkg::S_DROP_RD;
                else                     n_state = gwe_pkg::S_DONE;
            end
            gwe_pkg::S_DONE:    n_state = gwe_pkg::S_IDLE;
            default:            n_state = gwe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        busy            = (r_state != gwe_pkg::S_IDLE);
        o_valid         = 1'b0;
        case (r_state)
            gwe_pkg::S_IDLE:     o_cmd.accept    = start;
            gwe_pkg::S_TAKE:     o_cmd.take      = 1'b1;
            gwe_pkg::S_ROW:      o_cmd.latch_row = 1'b1;
            gwe_pkg::S_SCAN:     o_cmd.scan      = 1'b1;
            gwe_pkg::S_DROP_CHK: o_cmd.drop_pop  = i_stat.head_visited;
            gwe_pkg::S_DONE:     o_valid         = 1'b1;
            default:             o_cmd           = '0;
        endcase
    end

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gwe_pkg::S_DONE |=> r_state == gwe_pkg::S_IDLE)
        else $error("result state not left after one cycle");
    a_take_to_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gwe_pkg::S_TAKE |=> r_state == gwe_pkg::S_ROW)
        else $error("row fetch skipped after take");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> busy)
        else $error("accepted word did not raise busy");

endmodule

// ===== rtl/gwe_dpath.sv =====
// ---------------------------------------------------------------------------
// gwe_dpath
// Adjacency memory, pending store, visited map, pointers and result regs.
// ---------------------------------------------------------------------------
module gwe_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gwe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gwe_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic [1:0]                        i_req_type,
    input  logic [5:0]                        i_row_index,
    input  logic [63:0]                       i_row_bits,
    input  logic [5:0]                        i_start_node,
    input  gwe_pkg::t_dp_cmd                  i_cmd,
    output gwe_pkg::t_dp_stat                 o_stat,
    output logic [5:0]                        o_node,
    output logic                              o_more_left,
    output logic [1:0]                        o_status
);

    // configuration
    logic                          r_order, r_drop;
    logic [gwe_pkg::NCOUNT_W-1:0]  r_ncount;
    logic [gwe_pkg::NODE_W-1:0]    last_k;

    // adjacency memory, per-row valid bits stand in for the zero reset
    logic [63:0]                   r_adj [gwe_pkg::MAX_NODES];
    logic [gwe_pkg::MAX_NODES-1:0] r_adj_vld;
    logic [63:0]                   r_adj_rdata;
    logic                          r_adj_rvld;

    // pending store
    logic [gwe_pkg::NODE_W-1:0]    r_store [gwe_pkg::STORE_DEPTH];
    logic [gwe_pkg::NODE_W-1:0]    r_store_rdata;
    logic [gwe_pkg::STORE_AW-1:0]  r_head, r_tail, n_head, n_tail, rd_addr, wr_addr;
    logic [gwe_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                          wr_en;
    logic [gwe_pkg::NODE_W-1:0]    wr_data;

    logic [63:0]                   r_visited;
    logic [63:0]                   r_nb;
    logic [gwe_pkg::NODE_W-1:0]    r_k;
    logic [5:0]                    r_node;
    logic [1:0]                    r_status;

    logic                          full, pop, push_k, start_ok;

    always_comb begin
        if (r_ncount == '0)
            last_k = '0;
        else if (r_ncount > gwe_pkg::NCOUNT_W'(gwe_pkg::MAX_NODES))
            last_k = gwe_pkg::NODE_W'(gwe_pkg::MAX_NODES - 1);
        else
            last_k = gwe_pkg::NODE_W'(r_ncount - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= 1'b0;
            r_drop   <= 1'b0;
            r_ncount <= gwe_pkg::NCOUNT_W'(gwe_pkg::MAX_NODES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gwe_pkg::CFG_ORDER: r_order  <= i_cfg_wdata[0];
                gwe_pkg::CFG_DROP:  r_drop   <= i_cfg_wdata[0];
                gwe_pkg::CFG_NODES: r_ncount <= i_cfg_wdata[gwe_pkg::NCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // adjacency
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_req_type == gwe_pkg::REQ_LOAD)
            r_adj[i_row_index] <= i_row_bits;
        r_adj_rdata <= r_adj[r_store_rdata];
        r_adj_rvld  <= r_adj_vld[r_store_rdata];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_vld <= '0;
        end else if (i_cmd.accept && i_req_type == gwe_pkg::REQ_LOAD) begin
            r_adj_vld[i_row_index] <= 1'b1;
        end
    end

    // pending store: take end is head (FIFO) or tail-1 (LIFO)
    assign full     = (r_count == gwe_pkg::COUNT_W'(gwe_pkg::STORE_DEPTH));
    assign rd_addr  = r_order ? r_head : r_tail - 1'b1;
    assign start_ok = (i_start_node <= last_k);
    assign push_k   = i_cmd.scan && r_nb[r_k] && !r_visited[r_k] && !full;
    assign pop      = i_cmd.take || i_cmd.drop_pop;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_tail;
        wr_data = r_k;
        if (i_cmd.accept && i_req_type == gwe_pkg::REQ_START) begin
            wr_en   = start_ok;
            wr_addr = '0;
            wr_data = i_start_node;
        end else if (push_k) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_store[wr_addr] <= wr_data;
        r_store_rdata <= r_store[rd_addr];
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.accept && i_req_type == gwe_pkg::REQ_START) begin
            n_head  = '0;
            n_tail  = start_ok ? gwe_pkg::STORE_AW'(1) : '0;
            n_count = start_ok ? gwe_pkg::COUNT_W'(1) : '0;
        end else if (pop) begin
            if (r_order) n_head = r_head + 1'b1;
            else         n_tail = r_tail - 1'b1;
            n_count = r_count - 1'b1;
        end else if (push_k) begin
            n_tail  = r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_visited <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cmd.accept && i_req_type == gwe_pkg::REQ_START)
                r_visited <= '0;
            else if (i_cmd.take)
                r_visited[r_store_rdata] <= 1'b1;
        end
    end

    // scan state and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_row) begin
            r_nb <= r_adj_rvld ? r_adj_rdata : '0;
            r_k  <= '0;
        end else if (i_cmd.scan) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.take) r_node <= r_store_rdata;
        if (i_cmd.accept) begin
            r_node   <= '0;
            r_status <= (i_req_type == gwe_pkg::REQ_STEP && r_count == '0) ?
                        gwe_pkg::ST_EMPTY : gwe_pkg::ST_OK;
        end else if (i_cmd.scan && r_nb[r_k] && !r_visited[r_k] && full) begin
            r_status <= gwe_pkg::ST_FULL;
        end
    end

    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.scan_last    = (r_k == last_k);
    assign o_stat.head_visited = r_visited[r_store_rdata];
    assign o_stat.drop_en      = r_drop;

    assign o_node      = r_node;
    assign o_more_left = (r_count != '0);
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gwe_pkg::COUNT_W'(gwe_pkg::STORE_DEPTH))
        else $error("pending count above store depth");
    a_take_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |=> r_visited[r_node])
        else $error("taken node not marked visited");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_count != '0)
        else $error("pop from empty store");

endmodule

// ===== rtl/graph_walk_engine.sv =====
// ---------------------------------------------------------------------------
// graph_walk_engine
// Depth-first / breadth-first walk over a 64-node adjacency bit matrix.
// ---------------------------------------------------------------------------
//  channel   | handshake            | word
//  ----------+----------------------+------------------------------------------
//  request   | start && !busy       | i_req_type i_row_index i_row_bits i_start_node
//  result    | o_valid (one cycle)  | o_node o_more_left o_status
//  config    | i_cfg_we             | i_cfg_index i_cfg_wdata
//
//  Load, start and empty step: result in the cycle right after accept.
//  Step: the node at the store's take end is taken, its row fetched, and the
//  scan checks one neighbour column per cycle up to the effective node count.
//  With drop_visited set, visited entries at the take end are then dropped,
//  one read and check per entry through the store's single read port, until an
//  unvisited entry or an empty store. busy stays high through the result cycle.
//  Reset (synchronous, active low) clears pointers, visited map and row
//  valid bits at once; no clearing pass. The result cannot be stalled.
module graph_walk_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gwe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gwe_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [5:0]                    i_row_index,
    input  logic [63:0]                   i_row_bits,
    input  logic [5:0]                    i_start_node,
    output logic                          o_valid,
    output logic [5:0]                    o_node,
    output logic                          o_more_left,
    output logic [1:0]                    o_status
);

    gwe_pkg::t_dp_cmd  cmd;
    gwe_pkg::t_dp_stat stat;

    gwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy),
        .o_valid    (o_valid)
    );

    gwe_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_type   (i_req_type),
        .i_row_index  (i_row_index),
        .i_row_bits   (i_row_bits),
        .i_start_node (i_start_node),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_node       (o_node),
        .o_more_left  (o_more_left),
        .o_status     (o_status)
    );

endmodule
